// ===== rtl/core/nearest_prime_distance_assert.svh =====
// Assertion macros for the nearest prime distance block.
`ifndef NEAREST_PRIME_DISTANCE_ASSERT_SVH
`define NEAREST_PRIME_DISTANCE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define NPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define NPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define NPD_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/npd_pkg.sv =====
// Shared constants and types for the nearest prime distance block.
package npd_pkg;

    localparam int VALUE_WIDTH_DEF = 20;
    localparam int DIST_W          = 8;
    localparam int OUT_TDW         = 16;
    localparam logic [DIST_W-1:0] MAX_DIST = 8'd255;

    typedef struct packed {
        logic done;
        logic zero;
    } npd_rem_stat_t;

endpackage

// ===== rtl/core/nearest_prime_distance.sv =====
// Nearest prime distance: for each n, the distance to the closest prime, saturated at 255.
// One item in, one item out. The search tests n+k and then n-k for k = 0, 1, ... 255 and
// stops at the first prime; each odd candidate v is checked by trial division with odd d
// while d*d <= v, every division running on one shared bit-serial remainder unit at one
// dividend bit per cycle (VALUE_WIDTH+1 bits, at least 9). A prime candidate v thus costs
// far more than a composite one, which stops at its first divisor.
// s_tready is high only between items; a finished result waits in the output register.
module nearest_prime_distance
    import npd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // [VALUE_WIDTH-1:0] n
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_TDW-1:0]                  m_tdata    // [7:0] distance, [8] overflow
);

    localparam int CW = ((VALUE_WIDTH > DIST_W) ? VALUE_WIDTH : DIST_W) + 1;
    localparam int DW = CW / 2 + 2;
    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CAND = 3'd1;
    localparam logic [2:0] S_LOOP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [DIST_W-1:0] k_reg, k_next;
    logic              side_reg, side_next;
    logic [CW-1:0]     v_reg, v_next;
    logic [DW-1:0]     d_reg, d_next;
    logic [SW-1:0]     sq_reg, sq_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              ovf_reg, ovf_next;
    logic              mvalid_reg, mvalid_next;
    logic [DIST_W-1:0] mdist_reg, mdist_next;
    logic              movf_reg, movf_next;

    logic              div_start;
    npd_rem_stat_t     rem_stat;
    logic [CW-1:0]     cand;
    logic              is_prime, not_prime;
    logic              k_le_n;

    npd_rem #(.CW(CW), .DW(DW)) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .stat     (rem_stat)
    );

    assign k_le_n = {{(CW-DIST_W){1'b0}}, k_reg} <= n_reg;
    assign cand   = side_reg ? (n_reg - CW'(k_reg)) : (n_reg + CW'(k_reg));

    always_comb begin
        is_prime  = 1'b0;
        not_prime = 1'b0;
        case (state_reg)
            S_CAND: begin
                if (cand[CW-1:1] == '0) begin
                    not_prime = 1'b1;
                end else if (cand[CW-1:2] == '0) begin
                    is_prime = 1'b1;
                end else if (!cand[0]) begin
                    not_prime = 1'b1;
                end
            end
            S_LOOP: is_prime = sq_reg > {1'b0, v_reg};
            S_DIV:  not_prime = rem_stat.done && rem_stat.zero;
            default: ;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        side_next   = side_reg;
        v_next      = v_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        dist_next   = dist_reg;
        ovf_next    = ovf_reg;
        mvalid_next = mvalid_reg;
        mdist_next  = mdist_reg;
        movf_next   = movf_reg;
        div_start   = 1'b0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_next     = CW'(s_tdata[VALUE_WIDTH-1:0]);
                    k_next     = '0;
                    side_next  = 1'b0;
                    state_next = S_CAND;
                end
            end
            S_CAND: begin
                v_next  = cand;
                d_next  = DW'(3);
                sq_next = SW'(9);
                if (!is_prime && !not_prime) begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (!is_prime) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_stat.done && !rem_stat.zero) begin
                    d_next     = d_reg + DW'(2);
                    sq_next    = sq_reg + {{(SW-DW-2){1'b0}}, d_reg, 2'b00} + SW'(4);
                    state_next = S_LOOP;
                end
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdist_next  = dist_reg;
                    movf_next   = ovf_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (is_prime) begin
            dist_next  = k_reg;
            ovf_next   = 1'b0;
            state_next = S_DONE;
        end else if (not_prime) begin
            if (!side_reg && k_le_n) begin
                side_next  = 1'b1;
                state_next = S_CAND;
            end else if (k_reg == MAX_DIST) begin
                dist_next  = MAX_DIST;
                ovf_next   = 1'b1;
                state_next = S_DONE;
            end else begin
                k_next     = k_reg + DIST_W'(1);
                side_next  = 1'b0;
                state_next = S_CAND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        n_reg     <= n_next;
        k_reg     <= k_next;
        side_reg  <= side_next;
        v_reg     <= v_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        dist_reg  <= dist_next;
        ovf_reg   <= ovf_next;
        mdist_reg <= mdist_next;
        movf_reg  <= movf_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(OUT_TDW-DIST_W-1){1'b0}}, movf_reg, mdist_reg};

endmodule

// ===== rtl/core/npd_rem.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module npd_rem
    import npd_pkg::*;
#(
    parameter int CW = 21,
    parameter int DW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [CW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output npd_rem_stat_t stat
);

    localparam int CNTW = $clog2(CW + 1);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   dvd_reg, dvd_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DW:0]     trial;
    logic            ge;

    assign trial = {rem_reg, dvd_reg[CW-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = CNTW'(CW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            dvd_next = {dvd_reg[CW-2:0], 1'b0};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

// ===== rtl/core/npd_checker.sv =====
// Port-level checks for the nearest prime distance block, bound to the top level.
`include "nearest_prime_distance_assert.svh"

module npd_checker #(
    parameter int VALUE_WIDTH = 20
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [15:0]                      m_tdata
);

    `NPD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `NPD_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `NPD_ASSERT_IMP(a_ovf_saturates, aclk, aresetn, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'hFF)
    `NPD_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[15:9] == 7'd0)
    `NPD_ASSERT_NXT_ALL(a_reset_idle, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind nearest_prime_distance npd_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_npd_checker (.*);
